/* rtl/core/swsc_pkg.sv */
// Shared types and constants for the sliding-window sender control block.
package swsc_pkg;

  // Event codes
  localparam logic [1:0] OP_ACK     = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_EOD     = 2'd2;

  // Connection phases
  localparam logic [1:0] PH_UNCONN = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_FIN    = 2'd2;
  localparam logic [1:0] PH_CLOSED = 2'd3;

  // Result codes
  localparam logic [2:0] EV_IGNORED   = 3'd0;
  localparam logic [2:0] EV_ADVANCED  = 3'd1;
  localparam logic [2:0] EV_CONNECTED = 3'd2;
  localparam logic [2:0] EV_REFUSED   = 3'd3;
  localparam logic [2:0] EV_COMPLETE  = 3'd4;
  localparam logic [2:0] EV_BACKOFF   = 3'd5;
  localparam logic [2:0] EV_FINISHING = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_LENGTH = 8'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_PACKET_SIZE     = 16'd1200;
  localparam logic [15:0] RST_INITIAL_WINDOW  = 16'd4800;
  localparam logic [15:0] RST_MAX_WINDOW      = 16'd16800;
  localparam logic [31:0] RST_TRANSFER_LENGTH = 32'd0;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ack_number;
    logic [31:0] advertised_window;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  phase_now;
    logic [31:0] send_window;
    logic [31:0] congestion_window_now;
    logic [31:0] data_offset;
    logic [31:0] base_sequence;
    logic        wake_sender;
  } out_item_t;

  typedef struct packed {
    logic [15:0] packet_size;
    logic [15:0] initial_window;
    logic [15:0] max_window;
    logic [31:0] transfer_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] seq_base;
    logic [31:0] byte_offset;
    logic [31:0] cong_window;
    logic [31:0] recv_window;
    logic [31:0] window_now;
  } conn_state_t;

endpackage

/* rtl/core/sliding_window_sender_control.sv */
// Sliding-window sender control: connection phase and window bookkeeping.
//
// Events (acknowledgement, retransmission timeout, end of data) arrive as
// requests on the in_ channel; every request yields exactly one result on the
// out_ channel, carrying the event outcome and the updated phase, send window,
// congestion window, data offset and base sequence.
// An accepted request lands in an input register; once the output register is
// free or draining, the event logic updates the connection state and loads the
// output register, which drives out_valid and the result. One request per cycle
// is sustained while out_ready stays high; the event logic is combinational
// between the two registers.
// When out_ready is low the result holds, the input register still takes one
// more request, and in_ready then drops until the output register drains.
// Configuration writes on the cfg_ channel are always ready; they are meant
// for an idle block. Writing the initial window also reloads the congestion
// and send windows.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and returns the connection to the unconnected phase.
module sliding_window_sender_control (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  swsc_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output swsc_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  swsc_pkg::cfg_t        cfg;
  swsc_pkg::conn_state_t st_r;
  swsc_pkg::conn_state_t st_nxt;
  swsc_pkg::conn_state_t step_st;
  swsc_pkg::out_item_t   step_res;
  swsc_pkg::in_item_t    in_item_r;
  swsc_pkg::out_item_t   out_item_r;
  logic                  in_vld_r;
  logic                  in_vld_nxt;
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  logic                  fire;
  logic                  cfg_wr;
  logic                  iw_load;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign iw_load   = cfg_wr && (cfg_index == swsc_pkg::REG_INITIAL_WINDOW);

  swsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  swsc_step u_step (
    .item   (in_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (step_st),
    .res    (step_res)
  );

  // A held request moves to the output when the output register is free or draining.
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt  = in_ready ? in_valid : in_vld_r;
    out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
    st_nxt      = fire ? step_st : st_r;
    if (iw_load) begin
      st_nxt.cong_window = {16'd0, cfg_data[15:0]};
      st_nxt.window_now  = {16'd0, cfg_data[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      st_r.phase       <= swsc_pkg::PH_UNCONN;
      st_r.seq_base    <= 32'd0;
      st_r.byte_offset <= 32'd0;
      st_r.cong_window <= {16'd0, swsc_pkg::RST_INITIAL_WINDOW};
      st_r.recv_window <= 32'd0;
      st_r.window_now  <= {16'd0, swsc_pkg::RST_INITIAL_WINDOW};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/swsc_cfg_regs.sv */
// Configuration register file of the sender control block.
module swsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [swsc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [31:0]                        wr_data,
  output swsc_pkg::cfg_t                     cfg
);

  swsc_pkg::cfg_t cfg_r;
  swsc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        swsc_pkg::REG_PACKET_SIZE:     cfg_nxt.packet_size     = wr_data[15:0];
        swsc_pkg::REG_INITIAL_WINDOW:  cfg_nxt.initial_window  = wr_data[15:0];
        swsc_pkg::REG_MAX_WINDOW:      cfg_nxt.max_window      = wr_data[15:0];
        swsc_pkg::REG_TRANSFER_LENGTH: cfg_nxt.transfer_length = wr_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_size     <= swsc_pkg::RST_PACKET_SIZE;
      cfg_r.initial_window  <= swsc_pkg::RST_INITIAL_WINDOW;
      cfg_r.max_window      <= swsc_pkg::RST_MAX_WINDOW;
      cfg_r.transfer_length <= swsc_pkg::RST_TRANSFER_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/swsc_step.sv */
// Next-state and result logic for one event of the sender control block.
module swsc_step (
  input  swsc_pkg::in_item_t    item,
  input  swsc_pkg::conn_state_t st,
  input  swsc_pkg::cfg_t        cfg,
  output swsc_pkg::conn_state_t st_nxt,
  output swsc_pkg::out_item_t   res
);

  logic [32:0] fin_num;
  logic [32:0] win_end;
  logic [32:0] cong_sum;
  logic [31:0] cong_inc;
  logic [31:0] cong_half;
  logic [31:0] cong_dec;
  logic [31:0] psz;
  logic [31:0] wmax;
  logic [31:0] ack_min;
  logic [31:0] ack_win;
  logic [31:0] to_win;
  logic        data_ack;
  logic        in_window;
  logic [2:0]  ev;
  logic        wake;

  always_comb begin
    psz       = {16'd0, cfg.packet_size};
    wmax      = {16'd0, cfg.max_window};
    fin_num   = {1'b0, cfg.transfer_length} + 33'd2;
    win_end   = {1'b0, st.seq_base} + {1'b0, st.window_now};

    data_ack  = ((st.phase == swsc_pkg::PH_DATA) && (item.ack_number > 32'd1)) ||
                ((st.phase == swsc_pkg::PH_FIN) && ({1'b0, item.ack_number} < fin_num));
    in_window = (item.ack_number >= st.seq_base) && ({1'b0, item.ack_number} <= win_end);

    // Additive increase saturates at the top of the 32-bit range.
    cong_sum  = {1'b0, st.cong_window} + {1'b0, psz};
    cong_inc  = cong_sum[32] ? 32'hFFFF_FFFF : cong_sum[31:0];
    ack_min   = (cong_inc < item.advertised_window) ? cong_inc : item.advertised_window;
    // The floor is tested before the upper clamp, so odd settings pass through as given.
    if (ack_min < psz) begin
      ack_win = psz;
    end else if (ack_min > wmax) begin
      ack_win = wmax;
    end else begin
      ack_win = ack_min;
    end

    cong_half = {1'b0, st.cong_window[31:1]};
    cong_dec  = (cong_half < psz) ? psz : cong_half;
    to_win    = (cong_dec < st.recv_window) ? cong_dec : st.recv_window;

    st_nxt = st;
    ev     = swsc_pkg::EV_IGNORED;
    wake   = 1'b0;

    if (st.phase != swsc_pkg::PH_CLOSED) begin
      unique case (item.op)
        swsc_pkg::OP_ACK: begin
          st_nxt.recv_window = item.advertised_window;
          if (data_ack) begin
            if (in_window) begin
              st_nxt.byte_offset = st.byte_offset + (item.ack_number - st.seq_base);
              st_nxt.seq_base    = item.ack_number;
              st_nxt.cong_window = cong_inc;
              st_nxt.window_now  = ack_win;
              ev                 = swsc_pkg::EV_ADVANCED;
              wake               = 1'b1;
            end
          end else if ((st.phase == swsc_pkg::PH_FIN) &&
                       ({1'b0, item.ack_number} == fin_num)) begin
            st_nxt.phase = swsc_pkg::PH_CLOSED;
            ev           = swsc_pkg::EV_COMPLETE;
          end else if ((st.phase == swsc_pkg::PH_UNCONN) && (item.ack_number == 32'd1)) begin
            st_nxt.seq_base = 32'd1;
            st_nxt.phase    = swsc_pkg::PH_DATA;
            ev              = swsc_pkg::EV_CONNECTED;
            wake            = 1'b1;
          end else if ((st.phase == swsc_pkg::PH_UNCONN) && (item.ack_number == 32'd0)) begin
            st_nxt.phase = swsc_pkg::PH_CLOSED;
            ev           = swsc_pkg::EV_REFUSED;
          end
        end
        swsc_pkg::OP_TIMEOUT: begin
          st_nxt.cong_window = cong_dec;
          st_nxt.window_now  = to_win;
          ev                 = swsc_pkg::EV_BACKOFF;
          wake               = 1'b1;
        end
        swsc_pkg::OP_EOD: begin
          if (st.phase == swsc_pkg::PH_DATA) begin
            st_nxt.phase = swsc_pkg::PH_FIN;
            ev           = swsc_pkg::EV_FINISHING;
          end
        end
        default: begin
          ev = swsc_pkg::EV_IGNORED;
        end
      endcase
    end

    res.event_res             = ev;
    res.phase_now             = st_nxt.phase;
    res.send_window           = st_nxt.window_now;
    res.congestion_window_now = st_nxt.cong_window;
    res.data_offset           = st_nxt.byte_offset;
    res.base_sequence         = st_nxt.seq_base;
    res.wake_sender           = wake;
  end

endmodule

/* rtl/core/swsc_checker.sv */
// Port-level checker for the sender control block, bound to the top level.
module swsc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input swsc_pkg::out_item_t            out_item
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Refusal and completion always leave the connection closed.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_res == swsc_pkg::EV_COMPLETE ||
                  out_item.event_res == swsc_pkg::EV_REFUSED)
    |-> out_item.phase_now == swsc_pkg::PH_CLOSED)
    else $error("closing event without closed phase");

  // The sender is woken exactly on advance, connect and back-off.
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.wake_sender == (out_item.event_res == swsc_pkg::EV_ADVANCED ||
                                           out_item.event_res == swsc_pkg::EV_CONNECTED ||
                                           out_item.event_res == swsc_pkg::EV_BACKOFF))
    else $error("wake flag does not match event");

  // With no output stall, an accepted request is output after both registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after request");

endmodule

bind sliding_window_sender_control swsc_checker u_swsc_checker (.*);
